@@ hdl/iee_pkg.sv @@
// Shared types and constants for the infix expression evaluator.
`default_nettype none

package iee_pkg;

  // Pending operator codes
  localparam logic [1:0] OP_PLUS   = 2'd0;
  localparam logic [1:0] OP_MINUS  = 2'd1;
  localparam logic [1:0] OP_TIMES  = 2'd2;
  localparam logic [1:0] OP_DIVIDE = 2'd3;

  // Character codes
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_TIMES  = 8'h2A;
  localparam logic [7:0] CHAR_DIVIDE = 8'h2F;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  localparam int RESULT_WIDTH = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;        // offer to accept a request
    logic step_char;   // fold a digit into the number
    logic apply_now;   // apply the number without the iterative unit
    logic iter_start;  // launch the multiply/divide unit
    logic set_op;      // record the operator character
    logic finish;      // load the result and clear state
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic is_op;
    logic last;
    logic have_digits;
    logic quick;       // pending operation needs no iteration
    logic iter_done;
    logic out_busy;    // result slot full and not taken
  } ctrl_status_t;

endpackage

`default_nettype wire

@@ hdl/iee_char_if.sv @@
// Input channel carrying one expression character per request.
`default_nettype none

interface iee_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

@@ hdl/iee_result_if.sv @@
// Output channel carrying one evaluated result per request.
`default_nettype none

interface iee_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

`default_nettype wire

@@ hdl/iee_muldiv.sv @@
// Radix-2 iterative unit: wrapping multiply or truncating signed divide.
`default_nettype none

module iee_muldiv #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic         is_div,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic              done,
  output logic [W-1:0]      result
);

  localparam int CW = $clog2(W);

  logic          busy;
  logic [CW-1:0] cnt;
  logic          div_mode;
  logic          neg;
  logic [W-1:0]  acc;   // product or partial remainder
  logic [W-1:0]  x;     // multiplicand or dividend/quotient
  logic [W-1:0]  y;     // multiplier or divisor
  logic [W:0]    trial;
  logic          ge;
  logic [W-1:0]  a_mag;
  logic [W-1:0]  b_mag;

  // Operand magnitudes for division
  assign a_mag = a[W-1] ? (~a + W'(1)) : a;
  assign b_mag = b[W-1] ? (~b + W'(1)) : b;

  // Restoring trial subtract
  assign trial = {acc, x[W-1]};
  assign ge    = trial >= {1'b0, y};

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  // Iteration datapath: one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      div_mode <= is_div;
      neg      <= a[W-1] ^ b[W-1];
      acc      <= '0;
      x        <= is_div ? a_mag : a;
      y        <= is_div ? b_mag : b;
    end else if (busy) begin
      if (div_mode) begin
        acc <= ge ? W'(trial - {1'b0, y}) : trial[W-1:0];
        x   <= {x[W-2:0], ge};
      end else begin
        acc <= acc + (y[0] ? x : '0);
        x   <= {x[W-2:0], 1'b0};
        y   <= {1'b0, y[W-1:1]};
      end
    end
  end

  // Final sign fix for the quotient
  assign result = div_mode ? (neg ? (~x + W'(1)) : x) : acc;

endmodule

`default_nettype wire

@@ hdl/iee_datapath.sv @@
// Datapath: character decode, number build, term and sum registers, result slot.
`default_nettype none

module iee_datapath #(
  parameter int W = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  iee_char_if.sink                 expr,
  iee_result_if.source             result,
  input  wire iee_pkg::ctrl_cmd_t  cmd,
  output iee_pkg::ctrl_status_t    status
);

  logic [7:0]   ch;
  logic         last_r;
  logic [W-1:0] number_accum;
  logic         have_digits;
  logic [W-1:0] finished_sum;
  logic [W-1:0] current_term;
  logic [1:0]   pending_operator;
  logic         error_seen;

  logic         is_digit;
  logic         is_op;
  logic [1:0]   char_op;
  logic [3:0]   digit;
  logic         iter_done;
  logic [W-1:0] iter_result;
  logic signed [W-1:0] total;

  // Decode the held character
  assign is_digit = (ch >= iee_pkg::CHAR_ZERO) && (ch <= iee_pkg::CHAR_NINE);
  assign digit    = 4'(ch - iee_pkg::CHAR_ZERO);

  always_comb begin
    is_op   = 1'b1;
    char_op = iee_pkg::OP_PLUS;
    case (ch)
      iee_pkg::CHAR_PLUS:   char_op = iee_pkg::OP_PLUS;
      iee_pkg::CHAR_MINUS:  char_op = iee_pkg::OP_MINUS;
      iee_pkg::CHAR_TIMES:  char_op = iee_pkg::OP_TIMES;
      iee_pkg::CHAR_DIVIDE: char_op = iee_pkg::OP_DIVIDE;
      default:              is_op   = 1'b0;
    endcase
  end

  iee_muldiv #(.W(W)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.iter_start),
    .is_div (pending_operator == iee_pkg::OP_DIVIDE),
    .a      (current_term),
    .b      (number_accum),
    .done   (iter_done),
    .result (iter_result)
  );

  // Hold the accepted request
  assign expr.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (expr.valid && expr.ready) begin
      ch     <= expr.char_code;
      last_r <= expr.last_char;
    end
  end

  // Expression state
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      number_accum     <= '0;
      have_digits      <= 1'b0;
      finished_sum     <= '0;
      current_term     <= '0;
      pending_operator <= iee_pkg::OP_PLUS;
      error_seen       <= 1'b0;
    end else begin
      if (cmd.step_char && is_digit) begin
        number_accum <= {number_accum[W-4:0], 3'b000} + {number_accum[W-2:0], 1'b0}
                        + W'(digit);
        have_digits  <= 1'b1;
      end
      if (cmd.apply_now) begin
        number_accum <= '0;
        have_digits  <= 1'b0;
        unique case (pending_operator)
          iee_pkg::OP_PLUS: begin
            finished_sum <= finished_sum + current_term;
            current_term <= number_accum;
          end
          iee_pkg::OP_MINUS: begin
            finished_sum <= finished_sum + current_term;
            current_term <= ~number_accum + W'(1);
          end
          default: begin
            // Divide by zero: flag and drop the term
            error_seen   <= 1'b1;
            current_term <= '0;
          end
        endcase
      end
      if (cmd.iter_start) begin
        number_accum <= '0;
        have_digits  <= 1'b0;
      end
      if (iter_done) begin
        current_term <= iter_result;
      end
      if (cmd.set_op && is_op) begin
        pending_operator <= char_op;
      end
    end
  end

  // Result slot
  assign total = finished_sum + current_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.value <= iee_pkg::RESULT_WIDTH'(total);
      result.error <= error_seen;
    end
  end

  // Status to the controller
  assign status.in_valid    = expr.valid;
  assign status.is_op       = is_op;
  assign status.last        = last_r;
  assign status.have_digits = have_digits;
  assign status.quick       = (pending_operator == iee_pkg::OP_PLUS)
                           || (pending_operator == iee_pkg::OP_MINUS)
                           || ((pending_operator == iee_pkg::OP_DIVIDE)
                               && (number_accum == '0));
  assign status.iter_done   = iter_done;
  assign status.out_busy    = result.valid && !result.ready;

endmodule

`default_nettype wire

@@ hdl/iee_control.sv @@
// Controller state machine sequencing each character through the datapath.
`default_nettype none

module iee_control (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire iee_pkg::ctrl_status_t status,
  output iee_pkg::ctrl_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHAR   = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_ITER   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       need_apply;

  assign need_apply = status.have_digits && (status.is_op || status.last);

  // Advance the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (status.in_valid) begin
          state_next = S_CHAR;
        end
      end
      S_CHAR: begin
        cmd.step_char = 1'b1;
        state_next    = S_APPLY;
      end
      S_APPLY: begin
        if (need_apply && !status.quick) begin
          cmd.iter_start = 1'b1;
          state_next     = S_ITER;
        end else begin
          cmd.apply_now = need_apply;
          cmd.set_op    = 1'b1;
          state_next    = status.last ? S_FINISH : S_IDLE;
        end
      end
      S_ITER: begin
        if (status.iter_done) begin
          cmd.set_op = 1'b1;
          state_next = status.last ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/infix_expression_evaluator.sv @@
// Top level of the infix expression evaluator: controller plus datapath.
`default_nettype none

// Reads an expression one character per request (digits, + - * /; anything else
// is skipped) and, on the character flagged last_char, returns one result: the
// DATA_WIDTH-bit wrapped value sign-extended or cut to 32 bits, plus an error
// flag for division by zero. * and / bind tighter than + and -. A character that
// applies a * or a / by a nonzero number to the current term runs the shared
// shift-add/restoring-divide unit, and the last character also loads the result
// register. The next expression may start while a result still waits to be
// taken.
module infix_expression_evaluator #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  iee_char_if.sink     expr,
  iee_result_if.source result
);

  iee_pkg::ctrl_cmd_t    cmd;
  iee_pkg::ctrl_status_t status;

  iee_control u_control (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  iee_datapath #(.W(DATA_WIDTH)) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .expr   (expr),
    .result (result),
    .cmd    (cmd),
    .status (status)
  );

`ifndef ASSERT_OFF
  a_finish_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !status.out_busy)
    else $error("result loaded while previous result still held");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> result.valid)
    else $error("result not presented after finish");

  a_one_char_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (expr.valid && expr.ready) |=> !expr.ready)
    else $error("new request taken while a character is in work");

  a_no_start_while_iterating: assert property (@(posedge clk) disable iff (rst)
    cmd.iter_start |=> !cmd.iter_start && !cmd.take)
    else $error("iterative unit restarted or input taken during iteration");
`endif

endmodule

`default_nettype wire

@@ test/infix_expression_evaluator_test.sv @@
// Testbench for the infix expression evaluator: random expressions checked against a predictor.
`timescale 1ns / 100ps

module infix_expression_evaluator_test;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Predict each expression's value and hold the results still owed by the block
  class expr_result_board;
    typedef struct {
      logic [31:0] value;
      logic        error;
    } result_t;

    result_t     expected_results[$];
    logic [31:0] number_accum;
    logic [31:0] finished_sum;
    logic [31:0] current_term;
    logic        have_digits;
    logic        div_by_zero;
    logic [1:0]  pending_op;
    int          checked;
    int          zero_divides;
    int          failures;

    function new();
      clear_state();
      checked = 0;
      zero_divides = 0;
      failures = 0;
    endfunction

    function void clear_state();
      number_accum = '0;
      finished_sum = '0;
      current_term = '0;
      have_digits = 1'b0;
      div_by_zero = 1'b0;
      pending_op = iee_pkg::OP_PLUS;
    endfunction

    // Signed division truncated toward zero; the most negative value over -1 wraps to itself
    function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] ^ b[31]) ? -q : q;
    endfunction

    // Apply the number just read under the pending operator
    function void fold_number();
      logic [31:0] num;
      num = number_accum;
      case (pending_op)
        iee_pkg::OP_PLUS: begin
          finished_sum = finished_sum + current_term;
          current_term = num;
        end
        iee_pkg::OP_MINUS: begin
          finished_sum = finished_sum + current_term;
          current_term = -num;
        end
        iee_pkg::OP_TIMES: current_term = current_term * num;
        default: begin
          if (num == '0) begin
            div_by_zero = 1'b1;
            current_term = '0;
          end else begin
            current_term = quotient(current_term, num);
          end
        end
      endcase
      number_accum = '0;
      have_digits = 1'b0;
    endfunction

    // Queue one predicted result behind those already owed
    function void add_expected(result_t res);
      expected_results = {expected_results, res};
    endfunction

    // Advance the prediction by one accepted character request
    function void note_char(logic [7:0] c, logic last);
      result_t     res;
      logic        is_op;
      logic [1:0]  op;
      is_op = 1'b1;
      op = iee_pkg::OP_PLUS;
      case (c)
        iee_pkg::CHAR_PLUS:   op = iee_pkg::OP_PLUS;
        iee_pkg::CHAR_MINUS:  op = iee_pkg::OP_MINUS;
        iee_pkg::CHAR_TIMES:  op = iee_pkg::OP_TIMES;
        iee_pkg::CHAR_DIVIDE: op = iee_pkg::OP_DIVIDE;
        default:              is_op = 1'b0;
      endcase
      if (c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) begin
        number_accum = number_accum * 10 + (c - iee_pkg::CHAR_ZERO);
        have_digits = 1'b1;
      end else if (is_op) begin
        if (have_digits) fold_number();
        pending_op = op;
      end
      if (last) begin
        if (have_digits) fold_number();
        res.value = finished_sum + current_term;
        res.error = div_by_zero;
        if (div_by_zero) zero_divides++;
        add_expected(res);
        clear_state();
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("mismatch at %0t: %s", $time, msg);
    endfunction

    // Compare one delivered result with the oldest prediction
    function void check_result(logic [31:0] value, logic error);
      result_t want;
      checked++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result value %0d error %0b", $signed(value), error));
        return;
      end
      want = expected_results.pop_front();
      if (value !== want.value)
        note_failure($sformatf("value expected %0d got %0d", $signed(want.value),
                               $signed(value)));
      if (error !== want.error)
        note_failure($sformatf("error expected %0b got %0b", want.error, error));
    endfunction
  endclass

  logic clk;
  logic rst;

  iee_char_if   expr_bus ();
  iee_result_if result_bus ();

  infix_expression_evaluator dut (
    .clk    (clk),
    .rst    (rst),
    .expr   (expr_bus),
    .result (result_bus)
  );

  expr_result_board board;
  logic [7:0]       line_buf[$];
  int               burst_left = 0;
  int               chars_sent = 0;
  int               meaningful_sent = 0;
  int               expressions_sent = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Append one character to the expression being built
  function automatic void put_char(logic [7:0] c);
    line_buf = {line_buf, c};
  endfunction

  // Digits and operators are the characters the block acts on
  function automatic logic is_meaningful(logic [7:0] c);
    return (c >= iee_pkg::CHAR_ZERO && c <= iee_pkg::CHAR_NINE) ||
           c == iee_pkg::CHAR_PLUS || c == iee_pkg::CHAR_MINUS ||
           c == iee_pkg::CHAR_TIMES || c == iee_pkg::CHAR_DIVIDE;
  endfunction

  function automatic logic [7:0] ignored_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_meaningful(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] op_char();
    case ($urandom_range(0, 3))
      0:       return iee_pkg::CHAR_PLUS;
      1:       return iee_pkg::CHAR_MINUS;
      2:       return iee_pkg::CHAR_TIMES;
      default: return iee_pkg::CHAR_DIVIDE;
    endcase
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endfunction

  // Pad between tokens: spaces and stray bytes
  function automatic void maybe_gap();
    if ($urandom_range(0, 3) == 0) put_char(CHAR_SPACE);
    if ($urandom_range(0, 19) == 0) put_char(ignored_char());
  endfunction

  // Append a decimal number, mostly short, sometimes past the 32-bit wrap
  function automatic void push_number(logic after_divide);
    longint unsigned v;
    string           digits;
    int              pick;
    pick = $urandom_range(0, 19);
    if (after_divide && $urandom_range(0, 3) == 0) v = 0;
    else if (pick < 11) v = $urandom_range(0, 99);
    else if (pick < 14) v = $urandom_range(0, 99999);
    else if (pick < 16) v = {$urandom, $urandom} % 64'd1000000000000;
    else begin
      case (pick)
        16:      v = 64'd2147483648;
        17:      v = 64'd4294967295;
        18:      v = 64'd4294967296;
        default: v = 64'd42949672959;
      endcase
    end
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) digits = {"0", digits};
    for (int i = 0; i < digits.len(); i++) begin
      put_char(digits[i]);
      if (i + 1 < digits.len() && $urandom_range(0, 29) == 0)
        put_char($urandom_range(0, 1) ? CHAR_SPACE : ignored_char());
    end
  endfunction

  // Build one expression: mostly well formed, some pure noise
  function automatic void build_expression();
    int         operands;
    logic [7:0] op;
    line_buf.delete();
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 3))
          0, 1:    put_char(8'($urandom_range(0, 255)));
          2:       put_char(iee_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
          default: put_char(op_char());
        endcase
      end
      return;
    end
    operands = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) put_char(iee_pkg::CHAR_MINUS);
    op = iee_pkg::CHAR_PLUS;
    for (int k = 0; k < operands; k++) begin
      if (k > 0) begin
        op = op_char();
        maybe_gap();
        if ($urandom_range(0, 19) == 0) put_char(op_char());
        put_char(op);
        maybe_gap();
      end
      push_number(op == iee_pkg::CHAR_DIVIDE);
    end
    if ($urandom_range(0, 9) == 0) put_char(op_char());
    if ($urandom_range(0, 9) == 0) put_char(CHAR_SPACE);
  endfunction

  // Offer one character request in bursts with random gaps between them
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        expr_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    expr_bus.valid     <= 1'b1;
    expr_bus.char_code <= c;
    expr_bus.last_char <= last;
    @(posedge clk);
    while (!expr_bus.ready) @(posedge clk);
    board.note_char(c, last);
    chars_sent++;
    if (is_meaningful(c)) meaningful_sent++;
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], i == line_buf.size() - 1);
    expressions_sent++;
  endtask

  // Check every result taken from the block
  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready)
      board.check_result(result_bus.value, result_bus.error);
  end

  // Stall the result side in modes of random length, plus one long hold-off
  initial begin : result_sink
    int   hold_left;
    int   mode;
    int   mode_left;
    logic held;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    held = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && meaningful_sent >= 250) begin
        held = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          0:       result_bus.ready <= 1'b1;
          1:       result_bus.ready <= ($urandom_range(0, 3) != 0);
          default: result_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int random_start;
    board = new();
    rst <= 1'b1;
    expr_bus.valid     <= 1'b0;
    expr_bus.char_code <= 8'h00;
    expr_bus.last_char <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty expression made of a single ignored top byte
    line_buf.delete();
    put_char(8'hFF);
    send_line();
    // Division by zero, ending on an ignored zero byte
    line_buf.delete();
    push_text("9/0");
    put_char(8'h00);
    send_line();
    // Leading minus, truncating divide, precedence, trailing operator
    line_buf.delete();
    push_text("-7/2+3*4-");
    send_line();
    // Divisor wraps to all ones: most negative value over -1
    line_buf.delete();
    push_text("2147483648/42949672959");
    send_line();

    // Random expressions
    random_start = chars_sent;
    while (chars_sent - random_start < 850) begin
      build_expression();
      send_line();
    end
    expr_bus.valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (48) @(posedge clk);

    $display("Sent %0d expressions in %0d characters (%0d digits or operators).",
             expressions_sent, chars_sent, meaningful_sent);
    $display("Compared %0d results, %0d of them flagging a division by zero.",
             board.checked, board.zero_divides);
    if (board.failures == 0 && board.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
